/* hw/rtl/mfr_pkg.sv */
// shared types and constants of the multidrop frame receiver
// no dependencies; used by the channel interfaces, mfr_parser and the top level
package mfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int HDR_DEPTH  = 6;
    localparam int HDR_IDX_W  = 3;
    localparam int IDX_W      = 3;
    localparam int STATUS_W   = 2;

    localparam int MAX_DATA_DEF = 8;

    localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hFF;
    localparam logic [BYTE_W-1:0] OWN_ADDR_RST   = 8'd3;

    // header slots in arrival order
    localparam int HDR_DEST = 0;
    localparam int HDR_SRC  = 1;
    localparam int HDR_SEQ  = 2;
    localparam int HDR_CMD  = 3;
    localparam int HDR_CHAN = 4;
    localparam int HDR_SIZE = 5;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SRC   = 4'd1,
        PH_SEQ   = 4'd2,
        PH_CMD   = 4'd3,
        PH_CHAN  = 4'd4,
        PH_SIZE  = 4'd5,
        PH_DATA  = 4'd6,
        PH_CHECK = 4'd7
    } t_phase;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_FRAME = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD     = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_SIZE     = 2'd2
    } t_status;

    typedef logic [HDR_DEPTH-1:0][BYTE_W-1:0] t_hdr;

    typedef struct packed {
        t_kind             kind;
        t_hdr              hdr;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        t_status           status;
    } t_result;

endpackage

/* hw/rtl/mfr_rx_if.sv */
// receive channel: one 9-bit serial word per beat
// depends on mfr_pkg for the byte width
interface mfr_rx_if;
    logic                      valid;
    logic                      ready;
    logic [mfr_pkg::BYTE_W-1:0] rx_byte;
    logic                      address_mark;

    modport source (output valid, rx_byte, address_mark, input ready);
    modport sink   (input valid, rx_byte, address_mark, output ready);
endinterface

/* hw/rtl/mfr_res_if.sv */
// result channel: one payload byte or one end-of-frame report per beat
// depends on mfr_pkg for field widths
interface mfr_res_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [mfr_pkg::BYTE_W-1:0]   dest_address;
    logic [mfr_pkg::BYTE_W-1:0]   source_address;
    logic [mfr_pkg::BYTE_W-1:0]   sequence_id;
    logic [mfr_pkg::BYTE_W-1:0]   command_code;
    logic [mfr_pkg::BYTE_W-1:0]   channel_number;
    logic [mfr_pkg::BYTE_W-1:0]   payload_size;
    logic [mfr_pkg::BYTE_W-1:0]   data_byte;
    logic [mfr_pkg::IDX_W-1:0]    data_index;
    logic [mfr_pkg::STATUS_W-1:0] frame_status;

    modport source (
        output valid, result_kind, dest_address, source_address, sequence_id,
               command_code, channel_number, payload_size, data_byte,
               data_index, frame_status,
        input  ready
    );
    modport sink (
        input  valid, result_kind, dest_address, source_address, sequence_id,
               command_code, channel_number, payload_size, data_byte,
               data_index, frame_status,
        output ready
    );
endinterface

/* hw/rtl/mfr_parser.sv */
// frame parser: phase tracking, header capture, running checksum, result forming
// depends on mfr_pkg; instantiated by multidrop_frame_receiver
module mfr_parser #(
    parameter int MAX_DATA = mfr_pkg::MAX_DATA_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [mfr_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_mark,
    input  logic [mfr_pkg::BYTE_W-1:0]  i_own_address,
    output logic                        o_res_valid,
    output mfr_pkg::t_result            o_res
);
    import mfr_pkg::*;

    localparam int CNT_RAW = $clog2(MAX_DATA + 1);
    localparam int CNT_W   = (CNT_RAW < IDX_W) ? IDX_W : CNT_RAW;

    t_phase             r_phase, n_phase;
    logic [BYTE_W-1:0]  r_sum, n_sum;
    t_hdr               r_hdr, n_hdr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               addr_hit;

    assign addr_hit = (i_byte == i_own_address) || (i_byte == BROADCAST_ADDR);

    // next state and result for the beat in the input register
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_hdr       = r_hdr;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res.kind  = KIND_DATA;
        o_res.data  = '0;
        o_res.index = '0;
        o_res.status = ST_GOOD;
        if (i_step) begin
            if (i_mark) begin
                // address byte: restart on a hit, drop the frame otherwise
                if (addr_hit) begin
                    n_hdr[HDR_DEST] = i_byte;
                    n_sum           = i_byte;
                    n_count         = '0;
                    n_phase         = PH_SRC;
                end else begin
                    n_phase = PH_IDLE;
                end
            end else begin
                case (r_phase)
                    PH_SRC, PH_SEQ, PH_CMD, PH_CHAN, PH_SIZE: begin
                        n_hdr[r_phase[HDR_IDX_W-1:0]] = i_byte;
                        n_sum = r_sum + i_byte;
                        if (r_phase == PH_SIZE) begin
                            n_count = '0;
                            if (i_byte > BYTE_W'(MAX_DATA)) begin
                                o_res_valid  = 1'b1;
                                o_res.kind   = KIND_FRAME;
                                o_res.status = ST_SIZE;
                                n_phase      = PH_IDLE;
                            end else if (i_byte == '0) begin
                                n_phase = PH_CHECK;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end else begin
                            n_phase = t_phase'(r_phase + 4'd1);
                        end
                    end
                    PH_DATA: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_DATA;
                        o_res.data  = i_byte;
                        o_res.index = r_count[IDX_W-1:0];
                        n_sum       = r_sum + i_byte;
                        n_count     = r_count + 1'b1;
                        if (BYTE_W'(n_count) >= r_hdr[HDR_SIZE]) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_FRAME;
                        o_res.status = (~r_sum == i_byte) ? ST_GOOD : ST_CHECKSUM;
                        n_phase      = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
        o_res.hdr = n_hdr;
    end

    // frame control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    // header bytes, only read once written in the current frame
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DATA))
        else $error("payload count beyond limit");

    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (BYTE_W'(r_count) < r_hdr[HDR_SIZE]))
        else $error("payload phase with no bytes left");

    a_size_abort_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_SIZE) |-> (r_phase == PH_SIZE && !i_mark))
        else $error("size abort outside size byte");

    a_frame_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_FRAME) |=> (r_phase == PH_IDLE))
        else $error("frame result did not close the frame");

endmodule

/* hw/rtl/multidrop_frame_receiver.sv */
// top level of the multidrop frame receiver: input register, parser, result register
// depends on mfr_pkg, mfr_rx_if, mfr_res_if and mfr_parser
//
// Takes one 9-bit serial word per beat and sustains one beat per clock cycle
// while the result side keeps taking results. A word is captured in an input
// register, parsed there by mfr_parser, and its result (a payload byte or an
// end-of-frame report) lands in the result register that drives o_res. The
// input register holds a word while the result register waits, so the
// receive side keeps going for one more beat under a stalled result side.
// Frames start on an address-marked byte equal to own_address (reset 3) or
// the broadcast address 255; write own_address only while the block is idle.
// Payload longer than MAX_DATA aborts the frame with a size-error report.
module multidrop_frame_receiver #(
    parameter int MAX_DATA = mfr_pkg::MAX_DATA_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mfr_pkg::BYTE_W-1:0] i_cfg_wdata,
    mfr_rx_if.sink                     i_rx,
    mfr_res_if.source                  o_res
);
    import mfr_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_mark;
    logic [BYTE_W-1:0] r_own_address;
    logic              r_out_valid;
    t_result           r_out;
    logic              out_free;
    logic              step;
    logic              res_valid;
    t_result           res;

    // result register is free when empty or being taken
    assign out_free   = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    // own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDR_RST;
        end else if (i_cfg_we) begin
            r_own_address <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_mark <= i_rx.address_mark;
        end
    end

    mfr_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_mark        (r_in_mark),
        .i_own_address (r_own_address),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    // result beat fields
    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_out.kind;
    assign o_res.dest_address   = r_out.hdr[HDR_DEST];
    assign o_res.source_address = r_out.hdr[HDR_SRC];
    assign o_res.sequence_id    = r_out.hdr[HDR_SEQ];
    assign o_res.command_code   = r_out.hdr[HDR_CMD];
    assign o_res.channel_number = r_out.hdr[HDR_CHAN];
    assign o_res.payload_size   = r_out.hdr[HDR_SIZE];
    assign o_res.data_byte      = r_out.data;
    assign o_res.data_index     = r_out.index;
    assign o_res.frame_status   = r_out.status;

endmodule
